// ===== rtl/core/tfss_pkg.sv =====
package tfss_pkg;

   // Field widths
   localparam int TIME_US_W    = 64;
   localparam int WORD_W       = 32;
   localparam int SLOT_COUNT_W = 9;
   localparam int SLOT_INDEX_W = 8;
   localparam int KIND_W       = 2;
   localparam int DIV_COUNT_W  = $clog2(TIME_US_W);

   // Stream payload widths
   localparam int REQ_TDATA_W  = 160;
   localparam int RSP_FIELDS_W = 235;
   localparam int RSP_TDATA_W  = 240;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LEN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_LEN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WAIT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS_LIMIT  = 3'd5;

   // Register values after reset
   localparam logic                    RST_MASTER_MODE = 1'b0;
   localparam logic [WORD_W-1:0]       RST_FRAME_LEN   = 32'd100000;
   localparam logic [WORD_W-1:0]       RST_SLOT_LEN    = 32'd10000;
   localparam logic [SLOT_COUNT_W-1:0] RST_SLOT_COUNT  = 9'd10;
   localparam logic [WORD_W-1:0]       RST_SYNC_WAIT   = 32'd500;
   localparam logic [WORD_W-1:0]       RST_LOSS_LIMIT  = 32'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_START  = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_SYNC   = 2'd2,
      KIND_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_HOLD
   } fsm_state_type;

   typedef struct packed {
      logic                   wen;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   typedef struct packed {
      logic                    master_mode;
      logic [WORD_W-1:0]       frame_len_us;
      logic [WORD_W-1:0]       slot_len_us;
      logic [SLOT_COUNT_W-1:0] slot_count;
      logic [WORD_W-1:0]       sync_wait_ms;
      logic [WORD_W-1:0]       loss_limit;
   } cfg_type;

   // Timer view captured when an event is applied
   typedef struct packed {
      logic [WORD_W-1:0]    frame_number;
      logic [TIME_US_W-1:0] elapsed_us;
      logic                 lost_flag;
      logic [WORD_W-1:0]    missed_ticks;
      logic [WORD_W-1:0]    frames_total;
      logic [WORD_W-1:0]    losses_total;
      logic [WORD_W-1:0]    loss_duration_ms;
      logic                 broadcast_due;
      logic                 frame_advanced;
   } snap_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/core/tdma_frame_slot_sync_timer_unit.sv =====
// TDMA frame and slot timer with a slave sync watchdog. Each request beat is
// one event (start, tick or sync received, kind in req_tuser) stamped with the
// local microsecond and millisecond time, and yields exactly one response beat
// with the frame number, the clamped slot index and offset, the watchdog
// counters and the read-and-clear broadcast and frame-advanced flags. The
// event updates the timer state at the edge it is accepted; the slot index
// and offset then come from a shared restoring divider that retires one
// quotient bit per cycle over the 64-bit elapsed time, so the response beat
// is loaded once the divider is done and the output register is free, and
// the sequencer then returns to idle, ready to take the next event.
// req_tready is high only between events; a new event may be taken while the
// previous response still waits in the output register. Configuration writes
// take effect on the next cycle and must be issued only while no event is in
// flight.
module tdma_frame_slot_sync_timer_unit
   import tfss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_wen,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   // now_us[63:0], now_ms[95:64], remote_frame[127:96], remote_time_ms[159:128]
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // req_type[1:0]
   input  logic [KIND_W-1:0]       req_tuser,

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // frame_number[31:0], slot_index[39:32], slot_offset_us[71:40],
   // frame_offset_us[103:72], lost_flag[104], missed_ticks[136:105],
   // frames_total[168:137], losses_total[200:169], loss_duration_ms[232:201],
   // broadcast_due[233], frame_advanced[234], zero fill[239:235]
   output logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   fsm_state_type state_ff, state_in;

   csr_write_type  csr;
   cfg_type        cfg;
   snap_type       snap;
   div_status_type div_status;

   logic                   req_accept;
   logic                   out_free;
   logic                   div_start;
   logic                   load_out;
   logic [TIME_US_W-1:0]   quotient;
   logic [WORD_W-1:0]      remainder;

   logic [SLOT_COUNT_W-1:0] lim_full;
   logic [SLOT_INDEX_W-1:0] lim;
   logic                    over;
   logic [SLOT_INDEX_W-1:0] slot_index;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff,  rsp_data_in;

   assign csr.wen   = csr_wen;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   tfss_state u_state (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .evt_valid      (req_accept),
      .kind           (req_kind_type'(req_tuser)),
      .now_us         (req_tdata[63:0]),
      .now_ms         (req_tdata[95:64]),
      .remote_frame   (req_tdata[127:96]),
      .remote_time_ms (req_tdata[159:128]),
      .cfg            (cfg),
      .snap           (snap)
   );

   tfss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (snap.elapsed_us),
      .divisor   (cfg.slot_len_us),
      .status    (div_status),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_status.done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_START: div_start  = 1'b1;
         ST_DIV:   load_out   = div_status.done && out_free;
         ST_HOLD:  load_out   = out_free;
         default: ;
      endcase
   end

   // Clamp the quotient below the slot count, saturating at the index range
   always_comb begin
      lim_full   = (cfg.slot_count == '0) ? '0 : cfg.slot_count - SLOT_COUNT_W'(1);
      lim        = lim_full[SLOT_COUNT_W-1] ? '1 : lim_full[SLOT_INDEX_W-1:0];
      over       = (|quotient[TIME_US_W-1:SLOT_INDEX_W]) ||
                   (quotient[SLOT_INDEX_W-1:0] > lim);
      slot_index = over ? lim : quotient[SLOT_INDEX_W-1:0];
   end

   // Pack the response beat and hold it until taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_TDATA_W-RSP_FIELDS_W){1'b0}},
                         snap.frame_advanced,
                         snap.broadcast_due,
                         snap.loss_duration_ms,
                         snap.losses_total,
                         snap.frames_total,
                         snap.missed_ticks,
                         snap.lost_flag,
                         snap.elapsed_us[WORD_W-1:0],
                         remainder,
                         slot_index,
                         snap.frame_number};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_status.busy)
      else $error("divider busy while sequencer idle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_START))
      else $error("accepted event did not start the divider");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff)
      else $error("loaded response not presented");
`endif

endmodule

// ===== rtl/core/tfss_div.sv =====
module tfss_div
   import tfss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_US_W-1:0]  dividend,
   input  logic [WORD_W-1:0]     divisor,
   output div_status_type        status,
   output logic [TIME_US_W-1:0]  quotient,
   output logic [WORD_W-1:0]     remainder
);

   logic [WORD_W-1:0]      rem_ff,   rem_in;
   logic [TIME_US_W-1:0]   quot_ff,  quot_in;
   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;

   logic [WORD_W:0] partial;
   logic [WORD_W:0] diff;
   logic            fits;

   // One restoring step per cycle; a zero divisor always fits, which leaves
   // an all-ones quotient and the low word of the dividend as remainder
   always_comb begin
      partial  = {rem_ff, quot_ff[TIME_US_W-1]};
      fits     = partial >= {1'b0, divisor};
      diff     = partial - {1'b0, divisor};
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quot_in  = dividend;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[WORD_W-1:0] : partial[WORD_W-1:0];
         quot_in  = {quot_ff[TIME_US_W-2:0], fits};
         count_in = count_ff + DIV_COUNT_W'(1);
         if (count_ff == DIV_COUNT_W'(TIME_US_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/core/tfss_state.sv =====
module tfss_state
   import tfss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  csr_write_type        csr,
   input  logic                 evt_valid,
   input  req_kind_type         kind,
   input  logic [TIME_US_W-1:0] now_us,
   input  logic [WORD_W-1:0]    now_ms,
   input  logic [WORD_W-1:0]    remote_frame,
   input  logic [WORD_W-1:0]    remote_time_ms,
   output cfg_type              cfg,
   output snap_type             snap
);

   cfg_type cfg_ff, cfg_in;

   logic                 started_ff,     started_in;
   logic [WORD_W-1:0]    frame_count_ff, frame_count_in;
   logic [TIME_US_W-1:0] frame_start_ff, frame_start_in;
   logic                 adv_pend_ff,    adv_pend_in;
   logic                 bc_pend_ff,     bc_pend_in;
   logic [WORD_W-1:0]    last_sync_ff,   last_sync_in;
   logic [WORD_W-1:0]    missed_ff,      missed_in;
   logic [WORD_W-1:0]    opened_ff,      opened_in;
   logic [WORD_W-1:0]    loss_count_ff,  loss_count_in;
   logic [WORD_W-1:0]    loss_start_ff,  loss_start_in;
   logic                 lost_ff,        lost_in;
   snap_type             snap_ff,        snap_in;

   logic [TIME_US_W-1:0] elapsed_old;
   logic                 frame_due;
   logic [WORD_W-1:0]    sync_age;
   logic                 timed_out;
   logic [WORD_W-1:0]    missed_inc;
   logic                 restart;
   logic                 bc_evt;
   logic                 adv_evt;
   logic                 bcast;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.wen) begin
         case (csr.index)
            CSR_MASTER_MODE: cfg_in.master_mode  = csr.data[0];
            CSR_FRAME_LEN:   cfg_in.frame_len_us = csr.data;
            CSR_SLOT_LEN:    cfg_in.slot_len_us  = csr.data;
            CSR_SLOT_COUNT:  cfg_in.slot_count   = csr.data[SLOT_COUNT_W-1:0];
            CSR_SYNC_WAIT:   cfg_in.sync_wait_ms = csr.data;
            CSR_LOSS_LIMIT:  cfg_in.loss_limit   = csr.data;
            default: ;
         endcase
      end
   end

   // Apply one event to the timer and watchdog
   always_comb begin
      elapsed_old = now_us - frame_start_ff;
      frame_due   = elapsed_old >= {{(TIME_US_W-WORD_W){1'b0}}, cfg_ff.frame_len_us};
      sync_age    = now_ms - last_sync_ff;
      timed_out   = sync_age > cfg_ff.sync_wait_ms;
      missed_inc  = missed_ff + WORD_W'(1);

      started_in     = started_ff;
      frame_count_in = frame_count_ff;
      frame_start_in = frame_start_ff;
      adv_evt        = adv_pend_ff;
      bc_evt         = bc_pend_ff;
      last_sync_in   = last_sync_ff;
      missed_in      = missed_ff;
      opened_in      = opened_ff;
      loss_count_in  = loss_count_ff;
      loss_start_in  = loss_start_ff;
      lost_in        = lost_ff;
      restart        = 1'b0;

      case (kind)
         KIND_START: begin
            started_in     = 1'b1;
            frame_count_in = '0;
            frame_start_in = now_us;
            adv_evt        = 1'b0;
            bc_evt         = cfg_ff.master_mode;
            last_sync_in   = now_ms;
            missed_in      = '0;
            opened_in      = '0;
            loss_count_in  = '0;
            loss_start_in  = '0;
            lost_in        = 1'b0;
            restart        = 1'b1;
         end
         KIND_TICK: begin
            if (started_ff) begin
               if (frame_due) begin
                  frame_start_in = now_us;
                  frame_count_in = frame_count_ff + WORD_W'(1);
                  opened_in      = opened_ff + WORD_W'(1);
                  adv_evt        = 1'b1;
                  restart        = 1'b1;
                  if (cfg_ff.master_mode) begin
                     bc_evt = 1'b1;
                  end
               end
               if (!cfg_ff.master_mode && timed_out) begin
                  missed_in = missed_inc;
                  if (!lost_ff && missed_inc >= cfg_ff.loss_limit) begin
                     lost_in       = 1'b1;
                     loss_start_in = now_ms;
                     loss_count_in = loss_count_ff + WORD_W'(1);
                  end
               end
            end
         end
         KIND_SYNC: begin
            if (!cfg_ff.master_mode) begin
               frame_count_in = remote_frame;
               frame_start_in = now_us;
               last_sync_in   = remote_time_ms;
               missed_in      = '0;
               restart        = 1'b1;
               if (lost_ff) begin
                  lost_in       = 1'b0;
                  loss_start_in = '0;
               end
            end
         end
         KIND_UNUSED: ;
         default: ;
      endcase

      // Report and clear the pending flags
      bcast       = cfg_ff.master_mode && started_in && bc_evt;
      bc_pend_in  = bc_evt && !bcast;
      adv_pend_in = 1'b0;

      snap_in.frame_number     = frame_count_in;
      snap_in.elapsed_us       = restart ? '0 : elapsed_old;
      snap_in.lost_flag        = lost_in;
      snap_in.missed_ticks     = missed_in;
      snap_in.frames_total     = opened_in;
      snap_in.losses_total     = loss_count_in;
      snap_in.loss_duration_ms = lost_in ? (now_ms - loss_start_in) : '0;
      snap_in.broadcast_due    = bcast;
      snap_in.frame_advanced   = adv_evt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_mode  <= RST_MASTER_MODE;
         cfg_ff.frame_len_us <= RST_FRAME_LEN;
         cfg_ff.slot_len_us  <= RST_SLOT_LEN;
         cfg_ff.slot_count   <= RST_SLOT_COUNT;
         cfg_ff.sync_wait_ms <= RST_SYNC_WAIT;
         cfg_ff.loss_limit   <= RST_LOSS_LIMIT;
         started_ff     <= 1'b0;
         frame_count_ff <= '0;
         frame_start_ff <= '0;
         adv_pend_ff    <= 1'b0;
         bc_pend_ff     <= 1'b0;
         last_sync_ff   <= '0;
         missed_ff      <= '0;
         opened_ff      <= '0;
         loss_count_ff  <= '0;
         loss_start_ff  <= '0;
         lost_ff        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (evt_valid) begin
            started_ff     <= started_in;
            frame_count_ff <= frame_count_in;
            frame_start_ff <= frame_start_in;
            adv_pend_ff    <= adv_pend_in;
            bc_pend_ff     <= bc_pend_in;
            last_sync_ff   <= last_sync_in;
            missed_ff      <= missed_in;
            opened_ff      <= opened_in;
            loss_count_ff  <= loss_count_in;
            loss_start_ff  <= loss_start_in;
            lost_ff        <= lost_in;
         end
      end
      if (evt_valid) begin
         snap_ff <= snap_in;
      end
   end

   assign cfg  = cfg_ff;
   assign snap = snap_ff;

endmodule
